### src/dlmt_pkg.sv
package dlmt_pkg;

  typedef enum logic [1:0] {
    OP_TRANS = 2'd0,
    OP_ACCEPT = 2'd1,
    OP_BYTE = 2'd2,
    OP_END = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_TOKEN = 2'd0,
    KIND_ERROR = 2'd1,
    KIND_FINISH = 2'd2
  } kind_t;

  // What one evaluation step of the datapath does.
  typedef enum logic [1:0] {
    MODE_CHAR = 2'd0,
    MODE_FIN = 2'd1,
    MODE_RES = 2'd2
  } mode_t;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] entry_state;
    logic [6:0] entry_char;
    logic       entry_next_valid;
    logic [7:0] entry_next;
    logic       entry_accept_valid;
    logic [5:0] entry_accept_type;
    logic [7:0] source_byte;
  } src_word_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [5:0]  token_type;
    logic [31:0] token_start;
    logic [7:0]  token_length;
    logic        last_of_run;
  } res_word_t;

  typedef struct packed {
    logic  wr_trans;
    logic  latch_acc;
    logic  wr_acc;
    logic  load_byte;
    logic  look;
    logic  eval;
    logic  hread;
    logic  flush_last;
    mode_t mode;
  } cmd_t;

  typedef struct packed {
    logic halted;
    logic acc_pend;
    logic hold_valid;
    logic can_flush;
    logic ev_halt;
    logic ev_again;
    logic ev_more;
  } sts_t;

endpackage

### src/dlmt_ctrl.sv
module dlmt_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           src_valid,
  output logic           src_ready,
  input  logic [1:0]     src_op,
  input  dlmt_pkg::sts_t sts,
  output dlmt_pkg::cmd_t cmd
);
  import dlmt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_EVAL,
    S_HREAD,
    S_WRACC,
    S_FLUSH
  } state_t;

  state_t state;
  mode_t  mode;
  logic   finishing;
  logic   take;
  logic   go;

  assign src_ready = (state == S_IDLE);
  assign take = src_valid && src_ready;
  assign go = !sts.hold_valid || sts.can_flush;

  always_comb begin
    cmd = '0;
    cmd.mode = mode;
    unique case (state)
      S_IDLE: begin
        if (take) begin
          unique case (op_t'(src_op))
            OP_TRANS: cmd.wr_trans = 1'b1;
            OP_ACCEPT: cmd.latch_acc = 1'b1;
            OP_BYTE: cmd.load_byte = !sts.halted;
            OP_END: cmd.load_byte = 1'b0;
          endcase
        end
      end
      S_LOOK: cmd.look = 1'b1;
      S_EVAL: cmd.eval = go;
      S_HREAD: cmd.hread = 1'b1;
      S_WRACC: cmd.wr_acc = 1'b1;
      S_FLUSH: cmd.flush_last = 1'b1;
      default: cmd.look = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mode <= MODE_CHAR;
      finishing <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (take) begin
            unique case (op_t'(src_op))
              OP_TRANS: state <= S_IDLE;
              OP_ACCEPT: begin
                // A move whose accept check is still owed must see the old entry.
                if (sts.acc_pend) begin
                  mode <= MODE_RES;
                  state <= S_LOOK;
                end else begin
                  state <= S_WRACC;
                end
              end
              OP_BYTE: begin
                if (!sts.halted) begin
                  mode <= MODE_CHAR;
                  finishing <= 1'b0;
                  state <= S_LOOK;
                end
              end
              OP_END: begin
                if (!sts.halted) begin
                  mode <= MODE_FIN;
                  finishing <= 1'b1;
                  state <= S_LOOK;
                end
              end
            endcase
          end
        end
        S_LOOK: state <= S_EVAL;
        S_EVAL: begin
          if (go) begin
            priority if (mode == MODE_RES) begin
              state <= S_WRACC;
            end else if (sts.ev_halt) begin
              state <= S_FLUSH;
            end else if (sts.ev_again) begin
              state <= S_LOOK;
            end else if (sts.ev_more) begin
              mode <= MODE_CHAR;
              state <= S_HREAD;
            end else if (finishing) begin
              mode <= MODE_FIN;
              state <= S_LOOK;
            end else begin
              state <= S_FLUSH;
            end
          end
        end
        S_HREAD: state <= S_LOOK;
        S_WRACC: state <= S_IDLE;
        S_FLUSH: begin
          if (go) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### src/dlmt_path.sv
module dlmt_path #(
  parameter int STATE_COUNT = 256,
  parameter int TYPE_COUNT = 64,
  parameter int ALPHABET_SIZE = 128,
  parameter int LOOKAHEAD_DEPTH = 16,
  parameter int MAX_TOKEN_LENGTH = 255
) (
  input  logic                clk,
  input  logic                rst,
  input  dlmt_pkg::src_word_t src_word,
  input  dlmt_pkg::cmd_t      cmd,
  output dlmt_pkg::sts_t      sts,
  output logic                res_valid,
  input  logic                res_ready,
  output dlmt_pkg::res_word_t res_word
);
  import dlmt_pkg::*;

  localparam int SW = (STATE_COUNT > 2) ? $clog2(STATE_COUNT) : 1;
  localparam int CW = $clog2(ALPHABET_SIZE);
  localparam int TDEPTH = STATE_COUNT * (2 ** CW);
  localparam int HW = $clog2(LOOKAHEAD_DEPTH + 1);
  localparam int HDEPTH = 2 ** HW;
  localparam int LW = $clog2(MAX_TOKEN_LENGTH + 1);
  localparam int LAW = $clog2(LOOKAHEAD_DEPTH + 1);
  localparam logic [LW-1:0] MAXL = LW'(MAX_TOKEN_LENGTH);
  localparam logic [LAW-1:0] LDL = LAW'(LOOKAHEAD_DEPTH);

  typedef enum logic [1:0] {
    PH_OUT = 2'd0,
    PH_SLASH = 2'd1,
    PH_IN = 2'd2,
    PH_STAR = 2'd3
  } phase_t;

  logic [8:0] trans_mem [TDEPTH];
  logic [6:0] acc_mem [STATE_COUNT];
  logic [7:0] hist_mem [HDEPTH];

  logic [7:0]     scan_state;
  logic           best_valid;
  logic [5:0]     best_type;
  logic [LW-1:0]  best_length;
  logic [LW-1:0]  cur_len;
  logic [31:0]    start;
  logic [LAW-1:0] la_count;
  logic [31:0]    byte_pos;
  logic [31:0]    rp;
  phase_t         phase;
  logic           halted;
  logic           acc_pend;
  logic [7:0]     c;
  logic [31:0]    p;
  logic [8:0]     trans_rd;
  logic [6:0]     acc_rd;
  logic [7:0]     wa_state;
  logic           wa_valid;
  logic [5:0]     wa_type;
  logic           hold_valid;
  res_word_t      hold;

  logic           eff_bv;
  logic [5:0]     eff_bt;
  logic [LW-1:0]  eff_bl;
  logic [LAW-1:0] eff_la;
  logic [7:0]     state_next;
  logic           bv_next;
  logic [5:0]     bt_next;
  logic [LW-1:0]  bl_next;
  logic [LW-1:0]  cur_next;
  logic [31:0]    start_next;
  logic [LAW-1:0] la_next;
  logic           pend_next;
  phase_t         phase_next;
  logic [31:0]    rp_next;
  logic           halted_next;
  logic           ev_res;
  res_word_t      res;
  logic           do_dfa;
  logic           do_fail;
  logic           do_cut;
  logic           do_done;
  logic           slash_pre;
  logic [7:0]     dc;
  logic [31:0]    dp;
  logic           move;
  logic           is_space;
  logic [7:0]     look_ch;
  logic [7:0]     src_lc;
  logic           can_flush;
  logic           load_out;

  assign src_lc = (src_word.source_byte >= CH_UPPER_A && src_word.source_byte <= CH_UPPER_Z)
                  ? src_word.source_byte + CASE_OFFSET : src_word.source_byte;
  assign is_space = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  assign look_ch = (phase == PH_SLASH) ? CH_SLASH : c;

  always_comb begin
    eff_bv = best_valid;
    eff_bt = best_type;
    eff_bl = best_length;
    eff_la = la_count;
    // The accept check of the last move is folded in here, one byte late.
    if (acc_pend && acc_rd[6]) begin
      eff_bv = 1'b1;
      eff_bt = acc_rd[5:0];
      eff_bl = cur_len;
      eff_la = '0;
    end
    state_next = scan_state;
    bv_next = eff_bv;
    bt_next = eff_bt;
    bl_next = eff_bl;
    cur_next = cur_len;
    start_next = start;
    la_next = eff_la;
    pend_next = 1'b0;
    phase_next = phase;
    rp_next = rp;
    halted_next = halted;
    ev_res = 1'b0;
    res = '0;
    do_dfa = 1'b0;
    do_fail = 1'b0;
    do_cut = 1'b0;
    do_done = 1'b0;
    slash_pre = 1'b0;
    dc = c;
    dp = p;
    unique case (cmd.mode)
      MODE_CHAR: begin
        unique case (phase)
          PH_IN: begin
            if (c == CH_STAR) phase_next = PH_STAR;
          end
          PH_STAR: begin
            if (c == CH_SLASH) phase_next = PH_OUT;
            else if (c != CH_STAR) phase_next = PH_IN;
          end
          PH_SLASH: begin
            if (c == CH_STAR) begin
              phase_next = PH_IN;
            end else begin
              phase_next = PH_OUT;
              slash_pre = 1'b1;
            end
          end
          PH_OUT: begin
            priority if (cur_len == '0 && is_space) begin
              phase_next = PH_OUT;
            end else if (cur_len == '0 && c == CH_SLASH) begin
              phase_next = PH_SLASH;
              start_next = p;
            end else begin
              do_dfa = 1'b1;
            end
          end
        endcase
      end
      MODE_FIN: begin
        priority if (phase == PH_IN || phase == PH_STAR) begin
          do_fail = 1'b1;
        end else if (phase == PH_SLASH) begin
          phase_next = PH_OUT;
          slash_pre = 1'b1;
        end else if (cur_len == '0) begin
          do_done = 1'b1;
        end else if (!eff_bv) begin
          do_fail = 1'b1;
        end else begin
          do_cut = 1'b1;
        end
      end
      default: do_dfa = 1'b0;
    endcase

    // A slash held back at a token start is scanned before the byte after it.
    if (slash_pre) begin
      do_dfa = 1'b1;
      dc = CH_SLASH;
      dp = start;
    end

    move = trans_rd[8] && (32'(trans_rd[7:0]) < 32'(STATE_COUNT))
           && (32'(dc) < 32'(ALPHABET_SIZE));

    if (do_dfa) begin
      if (cur_len == '0) start_next = dp;
      priority if (cur_len >= MAXL) begin
        do_fail = 1'b1;
      end else if (eff_bv && eff_la >= LDL) begin
        do_fail = 1'b1;
      end else begin
        if (eff_bv) la_next = eff_la + 1'b1;
        if (!move) begin
          if (eff_bv) do_cut = 1'b1;
          else do_fail = 1'b1;
        end else begin
          cur_next = cur_len + 1'b1;
          state_next = trans_rd[7:0];
          pend_next = 1'b1;
        end
      end
    end

    if (do_fail) begin
      ev_res = 1'b1;
      res.result_kind = KIND_ERROR;
      res.token_start = start_next;
      res.token_length = 8'(cur_len);
      halted_next = 1'b1;
    end else if (do_cut) begin
      ev_res = 1'b1;
      res.result_kind = KIND_TOKEN;
      res.token_type = eff_bt;
      res.token_start = start_next;
      res.token_length = 8'(eff_bl);
      // Held characters are scanned again from just past the match.
      rp_next = start_next + 32'(eff_bl);
      state_next = '0;
      bv_next = 1'b0;
      bt_next = '0;
      bl_next = '0;
      cur_next = '0;
      la_next = '0;
      pend_next = 1'b0;
    end else if (do_done) begin
      ev_res = 1'b1;
      res.result_kind = KIND_FINISH;
      halted_next = 1'b1;
    end
  end

  assign can_flush = !res_valid || res_ready;
  assign load_out = hold_valid && ((cmd.eval && ev_res) || (cmd.flush_last && can_flush));

  assign sts.halted = halted;
  assign sts.acc_pend = acc_pend;
  assign sts.hold_valid = hold_valid;
  assign sts.can_flush = can_flush;
  assign sts.ev_halt = halted_next;
  assign sts.ev_again = slash_pre && !do_fail;
  assign sts.ev_more = (rp_next != byte_pos);

  // Tables and history.
  always_ff @(posedge clk) begin
    if (cmd.wr_trans && 32'(src_word.entry_state) < 32'(STATE_COUNT)) begin
      trans_mem[{SW'(src_word.entry_state), CW'(src_word.entry_char)}] <=
        {src_word.entry_next_valid, src_word.entry_next};
    end
    if (cmd.wr_acc && 32'(wa_state) < 32'(STATE_COUNT) && 32'(wa_type) < 32'(TYPE_COUNT)) begin
      acc_mem[SW'(wa_state)] <= {wa_valid, wa_type};
    end
    if (cmd.look) begin
      trans_rd <= trans_mem[{SW'(scan_state), look_ch[CW-1:0]}];
      acc_rd <= acc_mem[SW'(scan_state)];
    end
    if (cmd.load_byte) begin
      hist_mem[byte_pos[HW-1:0]] <= src_lc;
      c <= src_lc;
      p <= byte_pos;
    end
    if (cmd.hread) begin
      c <= hist_mem[rp[HW-1:0]];
      p <= rp;
    end
    if (cmd.latch_acc) begin
      wa_state <= src_word.entry_state;
      wa_valid <= src_word.entry_accept_valid;
      wa_type <= src_word.entry_accept_type;
    end
    if (cmd.eval && ev_res) begin
      hold <= res;
    end
    if (load_out) begin
      // The last bit of the word marks the final result of the item.
      res_word <= {hold[$bits(res_word_t)-1:1], cmd.flush_last};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_state <= '0;
      best_valid <= 1'b0;
      best_type <= '0;
      best_length <= '0;
      cur_len <= '0;
      start <= '0;
      la_count <= '0;
      byte_pos <= '0;
      rp <= '0;
      phase <= PH_OUT;
      halted <= 1'b0;
      acc_pend <= 1'b0;
      hold_valid <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (cmd.load_byte) begin
        byte_pos <= byte_pos + 32'd1;
        rp <= byte_pos + 32'd1;
      end
      if (cmd.hread) begin
        rp <= rp + 32'd1;
      end
      if (cmd.eval) begin
        scan_state <= state_next;
        best_valid <= bv_next;
        best_type <= bt_next;
        best_length <= bl_next;
        cur_len <= cur_next;
        start <= start_next;
        la_count <= la_next;
        acc_pend <= pend_next;
        phase <= phase_next;
        rp <= rp_next;
        halted <= halted_next;
        if (ev_res) hold_valid <= 1'b1;
      end
      if (cmd.flush_last && can_flush) begin
        hold_valid <= 1'b0;
      end
      if (load_out) res_valid <= 1'b1;
      else if (res_ready) res_valid <= 1'b0;
    end
  end

endmodule

### src/dfa_longest_match_tokenizer.sv
// Channel   Handshake             Word
// source    src_valid/src_ready   src_word: table writes, source bytes, end of input
// result    res_valid/res_ready   res_word: token, error or finish
//
// One item is taken at a time. A transition write goes into the table; an accept write
// first resolves the accept check of the last move if it is still owed. A fresh byte
// passes the accept step, the registered table read, the update and the hand-off of the
// last result. Each replayed character is read from history, looked up and updated. A
// lone slash adds a lookup and an update, as does each further end-word resolution step.
// Results pass a hold register and the output register; a stalled consumer holds the scan.
// Synchronous reset clears the scanner; the tables are not cleared.
module dfa_longest_match_tokenizer #(
  parameter int STATE_COUNT = 256,
  parameter int TYPE_COUNT = 64,
  parameter int ALPHABET_SIZE = 128,
  parameter int LOOKAHEAD_DEPTH = 16,
  parameter int MAX_TOKEN_LENGTH = 255
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                src_valid,
  output logic                src_ready,
  input  dlmt_pkg::src_word_t src_word,
  output logic                res_valid,
  input  logic                res_ready,
  output dlmt_pkg::res_word_t res_word
);
  import dlmt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  dlmt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_ready (src_ready),
    .src_op    (src_word.operation),
    .sts       (sts),
    .cmd       (cmd)
  );

  dlmt_path #(
    .STATE_COUNT      (STATE_COUNT),
    .TYPE_COUNT       (TYPE_COUNT),
    .ALPHABET_SIZE    (ALPHABET_SIZE),
    .LOOKAHEAD_DEPTH  (LOOKAHEAD_DEPTH),
    .MAX_TOKEN_LENGTH (MAX_TOKEN_LENGTH)
  ) u_path (
    .clk       (clk),
    .rst       (rst),
    .src_word  (src_word),
    .cmd       (cmd),
    .sts       (sts),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_word  (res_word)
  );

endmodule
